[src/dcr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_pkg
// Widths, stage counts and helpers shared by the disk collision response.
// ----------------------------------------------------------------------------
package dcr_pkg;

    localparam int CW          = 16;            // coordinate / velocity width
    localparam int MASS_W      = 16;
    localparam int RAD_W       = 15;
    localparam int DX_W        = CW + 1;        // centre difference
    localparam int PROD_W      = 2 * CW + 1;    // velocity * difference
    localparam int D2_W        = 2 * CW + 2;    // squared distance
    localparam int S_W         = 2 * CW + 2;    // dot product, signed
    localparam int DMAG_W      = 2 * CW + 2;    // |S_b - S_a|
    localparam int MSUM_W      = MASS_W + 1;    // mass sum, also 2 * mass
    localparam int HALF_W      = DMAG_W / 2;    // split point of the wide multiply
    localparam int PP_W        = MSUM_W + HALF_W;
    localparam int NUM_W       = DMAG_W + MSUM_W; // divider dividend
    localparam int DEN_W       = D2_W;          // divider divisor
    localparam int QA_W        = DMAG_W;        // |q_a| <= 2 * |S_b - S_a|
    localparam int ROOT_W      = D2_W / 2;
    localparam int OVL_W       = CW + 2;
    localparam int OVL_MAG_W   = CW + 1;
    localparam int SAT_W       = NUM_W + 2;
    localparam int DIV_STEPS   = NUM_W;
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int SQRT_TAP    = DIV_STEPS - SQRT_STEPS - 1;

    // clamp a wide signed value to the coordinate range
    function automatic logic [CW-1:0] sat_cw(input logic signed [SAT_W-1:0] v);
        logic [CW-1:0] r;
        if (!v[SAT_W-1] && (|v[SAT_W-2:CW-1]))
            r = {1'b0, {(CW-1){1'b1}}};
        else if (v[SAT_W-1] && !(&v[SAT_W-2:CW-1]))
            r = {1'b1, {(CW-1){1'b0}}};
        else
            r = v[CW-1:0];
        return r;
    endfunction

    // base + (+/- magnitude), saturated
    function automatic logic [CW-1:0] add_sat(input logic [NUM_W-1:0] mag,
                                              input logic neg,
                                              input logic signed [CW-1:0] base);
        logic signed [SAT_W-1:0] m;
        logic signed [SAT_W-1:0] s;
        m = signed'({2'b00, mag});
        if (neg)
            m = -m;
        s = m + SAT_W'(base);
        return sat_cw(s);
    endfunction

endpackage

[src/dcr_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_pair_if / dcr_resp_if
// Valid/ready channels for a colliding pair and its response.
// ----------------------------------------------------------------------------
interface dcr_pair_if import dcr_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [CW-1:0]     pos_a_x;
    logic signed [CW-1:0]     pos_a_y;
    logic signed [CW-1:0]     pos_b_x;
    logic signed [CW-1:0]     pos_b_y;
    logic signed [CW-1:0]     vel_a_x;
    logic signed [CW-1:0]     vel_a_y;
    logic signed [CW-1:0]     vel_b_x;
    logic signed [CW-1:0]     vel_b_y;
    logic [MASS_W-1:0]        mass_a;
    logic [MASS_W-1:0]        mass_b;
    logic [RAD_W-1:0]         radius_a;
    logic [RAD_W-1:0]         radius_b;

    modport source (output valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y,
                    vel_a_x, vel_a_y, vel_b_x, vel_b_y,
                    mass_a, mass_b, radius_a, radius_b,
                    input ready);
    modport sink   (input valid, pos_a_x, pos_a_y, pos_b_x, pos_b_y,
                    vel_a_x, vel_a_y, vel_b_x, vel_b_y,
                    mass_a, mass_b, radius_a, radius_b,
                    output ready);
endinterface

interface dcr_resp_if import dcr_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [CW-1:0]     new_vel_a_x;
    logic signed [CW-1:0]     new_vel_a_y;
    logic signed [CW-1:0]     new_vel_b_x;
    logic signed [CW-1:0]     new_vel_b_y;
    logic signed [CW-1:0]     new_pos_b_x;
    logic signed [CW-1:0]     new_pos_b_y;

    modport source (output valid, new_vel_a_x, new_vel_a_y, new_vel_b_x,
                    new_vel_b_y, new_pos_b_x, new_pos_b_y, input ready);
    modport sink   (input valid, new_vel_a_x, new_vel_a_y, new_vel_b_x,
                    new_vel_b_y, new_pos_b_x, new_pos_b_y, output ready);
endinterface

[src/dcr_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_div
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module dcr_div import dcr_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic [NUM_W-1:0] quo;
    } div_stage_t;

    function automatic div_stage_t div_step(input div_stage_t s);
        logic [DEN_W:0] trial;
        div_stage_t     r;
        trial = {s.rem, s.num[NUM_W-1]};
        r     = s;
        r.num = {s.num[NUM_W-2:0], 1'b0};
        if (trial >= {1'b0, s.den})
        begin
            r.rem = DEN_W'(trial - {1'b0, s.den});
            r.quo = {s.quo[NUM_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[DEN_W-1:0];
            r.quo = {s.quo[NUM_W-2:0], 1'b0};
        end
        return r;
    endfunction

    div_stage_t stage_reg [DIV_STEPS];
    div_stage_t init;

    assign init = '{rem: '0, num: num, den: den, quo: '0};

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_stage
        if (i == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                    stage_reg[i] <= div_step(init);
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (en)
                    stage_reg[i] <= div_step(stage_reg[i-1]);
            end
        end
    end

    assign quo = stage_reg[DIV_STEPS-1].quo;

endmodule

[src/dcr_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_sqrt
// Integer floor square root, one root bit per pipeline stage.
// ----------------------------------------------------------------------------
module dcr_sqrt import dcr_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [D2_W-1:0]   x,
    output logic [ROOT_W-1:0] root
);

    localparam int REM_W = ROOT_W + 2;
    localparam int TR_W  = REM_W + 2;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [D2_W-1:0]   x;
        logic [ROOT_W-1:0] root;
    } sq_stage_t;

    function automatic sq_stage_t sq_step(input sq_stage_t s);
        logic [TR_W-1:0] trial;
        logic [TR_W-1:0] t;
        sq_stage_t       r;
        trial = {s.rem, s.x[D2_W-1:D2_W-2]};
        t     = TR_W'({s.root, 2'b01});
        r     = s;
        r.x   = {s.x[D2_W-3:0], 2'b00};
        if (trial >= t)
        begin
            r.rem  = REM_W'(trial - t);
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = trial[REM_W-1:0];
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    sq_stage_t stage_reg [SQRT_STEPS];
    sq_stage_t init;

    assign init = '{rem: '0, x: x, root: '0};

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_stage
        if (i == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (en)
                    stage_reg[i] <= sq_step(init);
            end
        end
        else
        begin : g_rest
            always_ff @(posedge clk)
            begin
                if (en)
                    stage_reg[i] <= sq_step(stage_reg[i-1]);
            end
        end
    end

    assign root = stage_reg[SQRT_STEPS-1].root;

endmodule

[src/disk_elastic_collision_response_top.sv]
`timescale 1ns / 1ps
// Throughput: one pair per cycle; the whole pipeline advances together and
//   holds in place while the response register is full and not taken.
// The two levels of bit-per-stage dividers (51 stages each) lie in series.
// Reset: rst_n clears all valid bits at once; data registers are not reset.
// ----------------------------------------------------------------------------
// disk_elastic_collision_response_top
// Elastic collision of two disks: normal exchange of velocities with masses,
// then disk B is pushed along the normal by the overlap.
// ----------------------------------------------------------------------------
module disk_elastic_collision_response_top import dcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dcr_pair_if.sink   pair,
    dcr_resp_if.source resp
);

    // Fields that ride along the pipe up to P1.
    typedef struct packed {
        logic signed [DX_W-1:0] dx;
        logic signed [DX_W-1:0] dy;
        logic signed [CW-1:0]   pbx;
        logic signed [CW-1:0]   pby;
        logic signed [CW-1:0]   vax;
        logic signed [CW-1:0]   vay;
        logic signed [CW-1:0]   vbx;
        logic signed [CW-1:0]   vby;
        logic [RAD_W:0]         rs;      // radius_a + radius_b
        logic                   mz;      // both masses zero
    } base_t;

    typedef struct packed {
        base_t               b;
        logic [MASS_W-1:0]   ma;
        logic [MASS_W-1:0]   mb;
        logic [MSUM_W-1:0]   msum;
    } s1_t;

    typedef struct packed {
        base_t                    b;
        logic [MASS_W-1:0]        ma;
        logic [MASS_W-1:0]        mb;
        logic [MSUM_W-1:0]        msum;
        logic [D2_W-1:0]          sqx;
        logic [D2_W-1:0]          sqy;
        logic signed [PROD_W-1:0] pax;
        logic signed [PROD_W-1:0] pay;
        logic signed [PROD_W-1:0] pbx;
        logic signed [PROD_W-1:0] pby;
    } s2_t;

    typedef struct packed {
        base_t                 b;
        logic [MASS_W-1:0]     ma;
        logic [MASS_W-1:0]     mb;
        logic [MSUM_W-1:0]     msum;
        logic [D2_W-1:0]       d2;
        logic signed [S_W-1:0] sa;
        logic signed [S_W-1:0] sb;
    } s3_t;

    typedef struct packed {
        base_t               b;
        logic [MASS_W-1:0]   ma;
        logic [MASS_W-1:0]   mb;
        logic [MSUM_W-1:0]   msum;
        logic [D2_W-1:0]     d2;
        logic [DMAG_W-1:0]   dmag;
        logic                dneg;   // S_b - S_a < 0
    } s4_t;

    typedef struct packed {
        base_t               b;
        logic [MSUM_W-1:0]   msum;
        logic [D2_W-1:0]     d2;
        logic                dneg;
        logic [PP_W-1:0]     pa_lo;
        logic [PP_W-1:0]     pa_hi;
        logic [PP_W-1:0]     pb_lo;
        logic [PP_W-1:0]     pb_hi;
    } s5_t;

    typedef struct packed {
        base_t               b;
        logic [D2_W-1:0]     d2;
        logic                dneg;
    } side_a_t;

    typedef struct packed {
        side_a_t             sa;
        logic [MSUM_W-1:0]   msum;
        logic [NUM_W-1:0]    numa;
        logic [NUM_W-1:0]    numb;
    } s6_t;

    typedef struct packed {
        logic signed [CW-1:0] pbx;
        logic signed [CW-1:0] pby;
        logic signed [CW-1:0] vax;
        logic signed [CW-1:0] vay;
        logic signed [CW-1:0] vbx;
        logic signed [CW-1:0] vby;
        logic                 d2z;   // coincident centres
        logic                 mz;
        logic [5:0]           neg;   // vax, vay, vbx, vby, pbx, pby
    } side_c_t;

    typedef struct packed {
        side_c_t            sc;
        logic [NUM_W-1:0]   n_vax;
        logic [NUM_W-1:0]   n_vay;
        logic [NUM_W-1:0]   n_vbx;
        logic [NUM_W-1:0]   n_vby;
        logic [NUM_W-1:0]   n_pbx;
        logic [NUM_W-1:0]   n_pby;
        logic [DEN_W-1:0]   d2;
        logic [DEN_W-1:0]   dlen;
    } p1_t;

    // Global advance: everything moves when the response slot is free.
    logic adv;

    logic    out_valid_reg;
    logic [CW-1:0] out_vax_reg, out_vay_reg, out_vbx_reg, out_vby_reg;
    logic [CW-1:0] out_pbx_reg, out_pby_reg;

    logic [6:1] sv_reg;   // valid bits of the front stages
    s1_t     s1_reg, s1_next;
    s2_t     s2_reg, s2_next;
    s3_t     s3_reg, s3_next;
    s4_t     s4_reg, s4_next;
    s5_t     s5_reg, s5_next;
    s6_t     s6_reg, s6_next;

    side_a_t side_a_reg [DIV_STEPS];
    logic    va_reg     [DIV_STEPS];
    side_c_t side_c_reg [DIV_STEPS];
    logic    vc_reg     [DIV_STEPS];

    logic    p1_valid_reg;
    p1_t     p1_reg, p1_next;

    logic [NUM_W-1:0]  quo_a, quo_b;
    logic [NUM_W-1:0]  quo_vax, quo_vay, quo_vbx, quo_vby, quo_pbx, quo_pby;
    logic [ROOT_W-1:0] root;

    assign adv        = !out_valid_reg || resp.ready;
    assign pair.ready = adv;

    // ---- S1: centre difference, radius and mass sums ----
    always_comb
    begin
        s1_next.b.dx  = DX_W'(pair.pos_b_x) - DX_W'(pair.pos_a_x);
        s1_next.b.dy  = DX_W'(pair.pos_b_y) - DX_W'(pair.pos_a_y);
        s1_next.b.pbx = pair.pos_b_x;
        s1_next.b.pby = pair.pos_b_y;
        s1_next.b.vax = pair.vel_a_x;
        s1_next.b.vay = pair.vel_a_y;
        s1_next.b.vbx = pair.vel_b_x;
        s1_next.b.vby = pair.vel_b_y;
        s1_next.b.rs  = {1'b0, pair.radius_a} + {1'b0, pair.radius_b};
        s1_next.b.mz  = (pair.mass_a == '0) && (pair.mass_b == '0);
        s1_next.ma    = pair.mass_a;
        s1_next.mb    = pair.mass_b;
        s1_next.msum  = {1'b0, pair.mass_a} + {1'b0, pair.mass_b};
    end

    // ---- S2: squares and velocity projections ----
    always_comb
    begin
        s2_next.b    = s1_reg.b;
        s2_next.ma   = s1_reg.ma;
        s2_next.mb   = s1_reg.mb;
        s2_next.msum = s1_reg.msum;
        s2_next.sqx  = D2_W'(s1_reg.b.dx * s1_reg.b.dx);
        s2_next.sqy  = D2_W'(s1_reg.b.dy * s1_reg.b.dy);
        s2_next.pax  = PROD_W'(s1_reg.b.vax * s1_reg.b.dx);
        s2_next.pay  = PROD_W'(s1_reg.b.vay * s1_reg.b.dy);
        s2_next.pbx  = PROD_W'(s1_reg.b.vbx * s1_reg.b.dx);
        s2_next.pby  = PROD_W'(s1_reg.b.vby * s1_reg.b.dy);
    end

    // ---- S3: squared distance, dot products ----
    always_comb
    begin
        s3_next.b    = s2_reg.b;
        s3_next.ma   = s2_reg.ma;
        s3_next.mb   = s2_reg.mb;
        s3_next.msum = s2_reg.msum;
        s3_next.d2   = s2_reg.sqx + s2_reg.sqy;
        s3_next.sa   = S_W'(s2_reg.pax) + S_W'(s2_reg.pay);
        s3_next.sb   = S_W'(s2_reg.pbx) + S_W'(s2_reg.pby);
    end

    // ---- S4: |S_b - S_a| and its sign ----
    always_comb
    begin
        logic signed [S_W:0] diff;
        diff         = (S_W+1)'(s3_reg.sb) - (S_W+1)'(s3_reg.sa);
        s4_next.b    = s3_reg.b;
        s4_next.ma   = s3_reg.ma;
        s4_next.mb   = s3_reg.mb;
        s4_next.msum = s3_reg.msum;
        s4_next.d2   = s3_reg.d2;
        s4_next.dneg = diff[S_W];
        s4_next.dmag = diff[S_W] ? DMAG_W'(-diff) : DMAG_W'(diff);
    end

    // ---- S5: 2m * |diff| as two half-width partial products ----
    always_comb
    begin
        s5_next.b     = s4_reg.b;
        s5_next.msum  = s4_reg.msum;
        s5_next.d2    = s4_reg.d2;
        s5_next.dneg  = s4_reg.dneg;
        s5_next.pa_lo = {s4_reg.mb, 1'b0} * s4_reg.dmag[HALF_W-1:0];
        s5_next.pa_hi = {s4_reg.mb, 1'b0} * s4_reg.dmag[DMAG_W-1:HALF_W];
        s5_next.pb_lo = {s4_reg.ma, 1'b0} * s4_reg.dmag[HALF_W-1:0];
        s5_next.pb_hi = {s4_reg.ma, 1'b0} * s4_reg.dmag[DMAG_W-1:HALF_W];
    end

    // ---- S6: combine partial products, feed the mass dividers ----
    always_comb
    begin
        s6_next.sa.b    = s5_reg.b;
        s6_next.sa.d2   = s5_reg.d2;
        s6_next.sa.dneg = s5_reg.dneg;
        s6_next.msum    = s5_reg.msum;
        s6_next.numa    = (NUM_W'(s5_reg.pa_hi) << HALF_W) + NUM_W'(s5_reg.pa_lo);
        s6_next.numb    = (NUM_W'(s5_reg.pb_hi) << HALF_W) + NUM_W'(s5_reg.pb_lo);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg <= '0;
        else if (adv)
            sv_reg <= {sv_reg[5:1], pair.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            s6_reg <= s6_next;
        end
    end

    // ---- q_a, q_b magnitudes: |2m * diff| / (m_a + m_b) ----
    dcr_div u_div_qa (.clk(clk), .en(adv), .num(s6_reg.numa),
                      .den(DEN_W'(s6_reg.msum)), .quo(quo_a));
    dcr_div u_div_qb (.clk(clk), .en(adv), .num(s6_reg.numb),
                      .den(DEN_W'(s6_reg.msum)), .quo(quo_b));

    // side data tracks the divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
                va_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            va_reg[0] <= sv_reg[6];
            for (int i = 1; i < DIV_STEPS; i++)
                va_reg[i] <= va_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_a_reg[0] <= s6_reg.sa;
            for (int i = 1; i < DIV_STEPS; i++)
                side_a_reg[i] <= side_a_reg[i-1];
        end
    end

    // Square root starts late so that the root lines up with the quotients.
    dcr_sqrt u_sqrt (.clk(clk), .en(adv), .x(side_a_reg[SQRT_TAP].d2), .root(root));

    // ---- P1: scale the normal, form the overlap push ----
    always_comb
    begin
        side_a_t              a;
        logic                 dxn, dyn, on;
        logic [CW-1:0]        adx, ady;
        logic signed [OVL_W-1:0] ovl;
        logic [OVL_MAG_W-1:0] aovl;
        logic [QA_W-1:0]      qa, qb;
        a    = side_a_reg[DIV_STEPS-1];
        dxn  = a.b.dx[DX_W-1];
        dyn  = a.b.dy[DX_W-1];
        adx  = dxn ? CW'(-a.b.dx) : CW'(a.b.dx);
        ady  = dyn ? CW'(-a.b.dy) : CW'(a.b.dy);
        ovl  = OVL_W'(a.b.rs) - OVL_W'(root);
        on   = ovl[OVL_W-1];
        aovl = on ? OVL_MAG_W'(-ovl) : OVL_MAG_W'(ovl);
        qa   = quo_a[QA_W-1:0];
        qb   = quo_b[QA_W-1:0];

        p1_next.n_vax = NUM_W'(qa * adx);
        p1_next.n_vay = NUM_W'(qa * ady);
        p1_next.n_vbx = NUM_W'(qb * adx);
        p1_next.n_vby = NUM_W'(qb * ady);
        p1_next.n_pbx = NUM_W'(aovl * adx);
        p1_next.n_pby = NUM_W'(aovl * ady);
        p1_next.d2    = a.d2;
        p1_next.dlen  = DEN_W'(root);

        p1_next.sc.pbx = a.b.pbx;
        p1_next.sc.pby = a.b.pby;
        p1_next.sc.vax = a.b.vax;
        p1_next.sc.vay = a.b.vay;
        p1_next.sc.vbx = a.b.vbx;
        p1_next.sc.vby = a.b.vby;
        p1_next.sc.d2z = (a.d2 == '0);
        p1_next.sc.mz  = a.b.mz;
        // q_a carries the sign of S_b - S_a, q_b the opposite one
        p1_next.sc.neg = {a.dneg ^ dxn, a.dneg ^ dyn, !a.dneg ^ dxn, !a.dneg ^ dyn,
                          on ^ dxn, on ^ dyn};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_valid_reg <= 1'b0;
        else if (adv)
            p1_valid_reg <= va_reg[DIV_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            p1_reg <= p1_next;
    end

    // ---- velocity changes over D2, push over the integer distance ----
    dcr_div u_div_vax (.clk(clk), .en(adv), .num(p1_reg.n_vax), .den(p1_reg.d2),
                       .quo(quo_vax));
    dcr_div u_div_vay (.clk(clk), .en(adv), .num(p1_reg.n_vay), .den(p1_reg.d2),
                       .quo(quo_vay));
    dcr_div u_div_vbx (.clk(clk), .en(adv), .num(p1_reg.n_vbx), .den(p1_reg.d2),
                       .quo(quo_vbx));
    dcr_div u_div_vby (.clk(clk), .en(adv), .num(p1_reg.n_vby), .den(p1_reg.d2),
                       .quo(quo_vby));
    dcr_div u_div_pbx (.clk(clk), .en(adv), .num(p1_reg.n_pbx), .den(p1_reg.dlen),
                       .quo(quo_pbx));
    dcr_div u_div_pby (.clk(clk), .en(adv), .num(p1_reg.n_pby), .den(p1_reg.dlen),
                       .quo(quo_pby));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STEPS; i++)
                vc_reg[i] <= 1'b0;
        end
        else if (adv)
        begin
            vc_reg[0] <= p1_valid_reg;
            for (int i = 1; i < DIV_STEPS; i++)
                vc_reg[i] <= vc_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_c_reg[0] <= p1_reg.sc;
            for (int i = 1; i < DIV_STEPS; i++)
                side_c_reg[i] <= side_c_reg[i-1];
        end
    end

    // ---- output: apply signs, add, saturate, pick special cases ----
    logic [CW-1:0] vax_next, vay_next, vbx_next, vby_next, pbx_next, pby_next;

    always_comb
    begin
        side_c_t c;
        c        = side_c_reg[DIV_STEPS-1];
        vax_next = c.vax;
        vay_next = c.vay;
        vbx_next = c.vbx;
        vby_next = c.vby;
        pbx_next = c.pbx;
        pby_next = c.pby;
        if (!c.d2z)
        begin
            pbx_next = add_sat(quo_pbx, c.neg[1], c.pbx);
            pby_next = add_sat(quo_pby, c.neg[0], c.pby);
            if (!c.mz)
            begin
                vax_next = add_sat(quo_vax, c.neg[5], c.vax);
                vay_next = add_sat(quo_vay, c.neg[4], c.vay);
                vbx_next = add_sat(quo_vbx, c.neg[3], c.vbx);
                vby_next = add_sat(quo_vby, c.neg[2], c.vby);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= vc_reg[DIV_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_vax_reg <= vax_next;
            out_vay_reg <= vay_next;
            out_vbx_reg <= vbx_next;
            out_vby_reg <= vby_next;
            out_pbx_reg <= pbx_next;
            out_pby_reg <= pby_next;
        end
    end

    assign resp.valid       = out_valid_reg;
    assign resp.new_vel_a_x = out_vax_reg;
    assign resp.new_vel_a_y = out_vay_reg;
    assign resp.new_vel_b_x = out_vbx_reg;
    assign resp.new_vel_b_y = out_vby_reg;
    assign resp.new_pos_b_x = out_pbx_reg;
    assign resp.new_pos_b_y = out_pby_reg;

endmodule
